[hw/rtl/assert_macros.svh]
// Assertion macros shared by the find-and-replace RTL.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	`ASSERT_PROP(label, clk, rst_n, !(expr))

`endif

[hw/rtl/sfr_pkg.sv]
// Package for the streaming find-and-replace core: sizes, register indexes and types.
// Used by every module of the block; depends on nothing.
package sfr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 16;

	localparam int PAT_CAP = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
	localparam int REP_CAP = (REPLACE_MAX < 16) ? REPLACE_MAX : 16;

	localparam int PAT_BYTES = 8;
	localparam int REP_BYTES = 16;

	localparam int FILL_W = $clog2(PAT_CAP + 1);
	localparam int LIDX_W = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
	localparam int RLEN_W = $clog2(REP_CAP + 1);
	localparam int RIDX_W = $clog2(REP_BYTES);
	localparam int JLEN_W = $clog2(REP_CAP + PAT_CAP + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH = 3'd4;

	typedef struct packed {
		logic [FILL_W-1:0] plen;
		logic [PAT_BYTES-1:0][7:0] pattern;
		logic [RLEN_W-1:0] rlen;
		logic [REP_BYTES-1:0][7:0] repl;
	} cfg_t;

	typedef struct packed {
		logic [RLEN_W-1:0] rep_len;
		logic [JLEN_W-1:0] len;
		logic last;
		logic [PAT_CAP-1:0][7:0] lit;
	} job_t;

endpackage

[hw/rtl/sfr_front.sv]
// Front end: accepts input beats, keeps the pending-byte window and matches the pattern.
// An accepted beat with bytes to emit becomes one back-end job. Depends on sfr_pkg.
`include "assert_macros.svh"

module sfr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic data_valid,
	output logic data_stall,
	input  logic [7:0] data_byte,
	input  logic end_of_string,
	input  sfr_pkg::cfg_t cfg,
	input  logic fifo_full,
	output logic push,
	output sfr_pkg::job_t job
);
	import sfr_pkg::*;

	logic [PAT_CAP-1:0][7:0] win_q;
	logic [FILL_W-1:0] fill_q;

	logic [PAT_CAP-1:0][7:0] nw;
	logic [PAT_CAP-1:0][7:0] rem;
	logic [FILL_W-1:0] nfill;
	logic [FILL_W-1:0] drop;
	logic [FILL_W-1:0] remfill;
	logic [FILL_W-1:0] lcnt;
	logic check;
	logic match;
	logic hit;
	logic emit_one;
	logic accept;

	assign data_stall = fifo_full;
	assign accept = data_valid && !data_stall;

	always_comb begin
		for (int i = 0; i < PAT_CAP; i++) begin
			nw[i] = (FILL_W'(i) == fill_q) ? data_byte : win_q[i];
		end
		nfill = fill_q + 1'b1;
		check = (nfill >= cfg.plen);
		match = 1'b1;
		for (int i = 0; i < PAT_CAP; i++) begin
			if (FILL_W'(i) < cfg.plen && nw[i] != cfg.pattern[i]) begin
				match = 1'b0;
			end
		end
		hit = check && match;
		emit_one = check && !match;
		drop = hit ? cfg.plen : (emit_one ? FILL_W'(1) : FILL_W'(0));
		rem = nw >> {drop, 3'b000};
		remfill = nfill - drop;
		lcnt = (emit_one ? FILL_W'(1) : FILL_W'(0)) + (end_of_string ? remfill : FILL_W'(0));

		job.rep_len = hit ? cfg.rlen : RLEN_W'(0);
		job.len = JLEN_W'(job.rep_len) + JLEN_W'(lcnt);
		job.last = end_of_string;
		job.lit = hit ? rem : nw;
		push = accept && (job.len != JLEN_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= end_of_string ? FILL_W'(0) : remfill;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= rem;
		end
	end

	`ASSERT_NEVER(a_fill_range, clk, arst_n, fill_q > FILL_W'(PAT_CAP - 1))

endmodule

[hw/rtl/sfr_job_fifo.sv]
// Short job queue between the front end and the back end.
// Holds job_t entries with a combinational head. Depends on sfr_pkg.
`include "assert_macros.svh"

module sfr_job_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sfr_pkg::job_t push_job,
	input  logic pop,
	output sfr_pkg::job_t head,
	output logic full,
	output logic empty
);
	import sfr_pkg::*;

	job_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head = mem_q[rd_ptr_q];
	assign full = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty = (count_q == CNT_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? PTR_W'(0) : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? PTR_W'(0) : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty)
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(FIFO_DEPTH))

endmodule

[hw/rtl/sfr_back.sv]
// Back end: walks the head job byte by byte into the output register.
// Replacement bytes come first, then the literal bytes of the job. Depends on sfr_pkg.
`include "assert_macros.svh"

module sfr_back (
	input  logic clk,
	input  logic arst_n,
	input  sfr_pkg::cfg_t cfg,
	input  sfr_pkg::job_t head,
	input  logic empty,
	output logic pop,
	output logic result_valid,
	input  logic result_stall,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic string_done
);
	import sfr_pkg::*;

	logic [JLEN_W-1:0] pos_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic run_last_q;
	logic string_done_q;

	logic load;
	logic step;
	logic fin;
	logic rep_phase;
	logic [LIDX_W-1:0] lidx;
	logic [JLEN_W-1:0] ldiff;
	logic [7:0] cur_byte;

	always_comb begin
		load = !out_valid_q || !result_stall;
		step = load && !empty;
		fin = (pos_q + 1'b1 == head.len);
		pop = step && fin;
		rep_phase = (pos_q < JLEN_W'(head.rep_len));
		ldiff = pos_q - JLEN_W'(head.rep_len);
		lidx = ldiff[LIDX_W-1:0];
		cur_byte = rep_phase ? cfg.repl[pos_q[RIDX_W-1:0]] : head.lit[lidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				pos_q <= fin ? JLEN_W'(0) : pos_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= cur_byte;
			run_last_q <= fin;
			string_done_q <= fin && head.last;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;
	assign string_done = string_done_q;

	`ASSERT_PROP(a_pos_in_job, clk, arst_n, !empty |-> (pos_q < head.len))
	`ASSERT_PROP(a_pos_restart, clk, arst_n, pop |=> (pos_q == JLEN_W'(0)))

endmodule

[hw/rtl/stream_find_replace_core.sv]
// Top level of the streaming find-and-replace core: configuration registers and wiring.
// Depends on sfr_pkg, sfr_front, sfr_job_fifo and sfr_back.
//
// Channel   Signals                                           Beat moves
// input     data_valid, data_stall, data_byte, end_of_string  one string byte
// output    result_valid, result_stall, out_byte, ...         one rewritten byte
// config    cfg_valid, cfg_ready, cfg_index, cfg_data         one register write
//
// A plain byte passes a queue entry and the output register; unless stalled, input and
// output each move one beat per cycle. A matched run leaves as replacement_length beats,
// and a string's last byte adds one per pending byte; the output register paces them.
// A four-entry job queue lets the input side run ahead while the output side is stalled.
// Reset empties the window and the queue and loads the register defaults at once.
module stream_find_replace_core (
	input  logic clk,
	input  logic arst_n,
	input  logic data_valid,
	output logic data_stall,
	input  logic [7:0] data_byte,
	input  logic end_of_string,
	output logic result_valid,
	input  logic result_stall,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic string_done,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfr_pkg::*;

	logic [3:0] plen_q;
	logic [63:0] pattern_q;
	logic [4:0] rlen_q;
	logic [63:0] repl_low_q;
	logic [63:0] repl_high_q;

	cfg_t cfg;
	job_t push_job;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= 4'd1;
			pattern_q <= '0;
			rlen_q <= '0;
			repl_low_q <= '0;
			repl_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: begin
					plen_q <= cfg_data[3:0];
				end
				REG_PATTERN_BYTES: begin
					pattern_q <= cfg_data;
				end
				REG_REPLACEMENT_LENGTH: begin
					rlen_q <= cfg_data[4:0];
				end
				REG_REPLACEMENT_LOW: begin
					repl_low_q <= cfg_data;
				end
				REG_REPLACEMENT_HIGH: begin
					repl_high_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (plen_q == 4'd0) begin
			cfg.plen = FILL_W'(1);
		end else if (plen_q > 4'(PAT_CAP)) begin
			cfg.plen = FILL_W'(PAT_CAP);
		end else begin
			cfg.plen = FILL_W'(plen_q);
		end
		cfg.rlen = (rlen_q > 5'(REP_CAP)) ? RLEN_W'(REP_CAP) : RLEN_W'(rlen_q);
		cfg.pattern = pattern_q;
		cfg.repl = {repl_high_q, repl_low_q};
	end

	sfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.end_of_string(end_of_string),
		.cfg(cfg),
		.fifo_full(full),
		.push(push),
		.job(push_job)
	);

	sfr_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	sfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head(head),
		.empty(empty),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.string_done(string_done)
	);

endmodule
